[hw/rtl/bvht_pkg.sv]
package bvht_pkg;

    localparam int TIME_W     = 48;
    localparam int PRES_W     = 32;
    localparam int ALT_W      = 24;
    localparam int TEMP_W     = 16;
    localparam int AGE_W      = 32;
    localparam int CFG_P_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DT_W       = 32;
    localparam int DEN_W      = DT_W + 4;
    localparam int DA_W       = ALT_W + 1;
    localparam int PA_W       = 51;
    localparam int PB_W       = ALT_W + DT_W + 1;
    localparam int NUM_W      = 60;
    localparam int MAG_W      = NUM_W - 1;
    localparam int QUO_W      = ALT_W;
    localparam int REM_W      = DEN_W;
    localparam int CNT_W      = 5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    localparam logic signed [25:0] SPEED_K = 26'sd30000000;

    localparam logic [ALT_W-1:0] CLIMB_MAX = {1'b0, {(ALT_W-1){1'b1}}};
    localparam logic [ALT_W-1:0] CLIMB_MIN = {1'b1, {(ALT_W-1){1'b0}}};

    localparam logic [CFG_P_W-1:0] RST_MIN_P    = 18'd30000;
    localparam logic [CFG_P_W-1:0] RST_MAX_P    = 18'd120000;
    localparam logic [TEMP_W-1:0]  RST_MIN_T    = 16'hF060;
    localparam logic [TEMP_W-1:0]  RST_MAX_T    = 16'd12500;
    localparam logic [AGE_W-1:0]   RST_STALE    = 32'd500000;
    localparam logic [DT_W-1:0]    RST_MIN_IV   = 32'd5000;
    localparam logic [DT_W-1:0]    RST_MAX_IV   = 32'd1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_T   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_T   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IV  = 3'd6;

    typedef enum logic [1:0] {
        HEALTH_INIT    = 2'd0,
        HEALTH_OK      = 2'd1,
        HEALTH_STALE   = 2'd2,
        HEALTH_INVALID = 2'd3
    } t_health;

    typedef struct packed {
        logic capture;
        logic check;
        logic mul;
        logic sum;
        logic mag;
        logic div_init;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic upd;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/bvht_in_if.sv]
interface bvht_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [bvht_pkg::PRES_W-1:0] pressure;
    logic signed [bvht_pkg::ALT_W-1:0]  altitude;
    logic signed [bvht_pkg::TEMP_W-1:0] temperature;
    logic        [bvht_pkg::TIME_W-1:0] time_us;

    modport source (
        output valid, mode, pressure, altitude, temperature, time_us,
        input  ready
    );
    modport sink (
        input  valid, mode, pressure, altitude, temperature, time_us,
        output ready
    );
endinterface

[hw/rtl/bvht_out_if.sv]
interface bvht_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         health;
    logic                               sample_valid;
    logic signed [bvht_pkg::ALT_W-1:0]  altitude_out;
    logic signed [bvht_pkg::ALT_W-1:0]  climb_rate;
    logic        [bvht_pkg::AGE_W-1:0]  age;
    logic signed [bvht_pkg::PRES_W-1:0] pressure_out;
    logic signed [bvht_pkg::TEMP_W-1:0] temperature_out;

    modport source (
        output valid, health, sample_valid, altitude_out, climb_rate, age,
               pressure_out, temperature_out,
        input  ready
    );
    modport sink (
        input  valid, health, sample_valid, altitude_out, climb_rate, age,
               pressure_out, temperature_out,
        output ready
    );
endinterface

[hw/rtl/bvht_ctrl.sv]
module bvht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output bvht_pkg::t_cmd   o_cmd,
    input  bvht_pkg::t_sts   i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_SUM,
        ST_MAG,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_sts.upd ? ST_SUM : ST_EMIT;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/bvht_dp.sv]
module bvht_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bvht_pkg::t_cmd                       i_cmd,
    output bvht_pkg::t_sts                       o_sts,
    input  logic                                 i_cfg_we,
    input  logic [bvht_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bvht_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_mode,
    input  logic signed [bvht_pkg::PRES_W-1:0]   i_pressure,
    input  logic signed [bvht_pkg::ALT_W-1:0]    i_altitude,
    input  logic signed [bvht_pkg::TEMP_W-1:0]   i_temperature,
    input  logic [bvht_pkg::TIME_W-1:0]          i_time_us,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_health,
    output logic                                 o_sample_valid,
    output logic signed [bvht_pkg::ALT_W-1:0]    o_altitude_out,
    output logic signed [bvht_pkg::ALT_W-1:0]    o_climb_rate,
    output logic [bvht_pkg::AGE_W-1:0]           o_age,
    output logic signed [bvht_pkg::PRES_W-1:0]   o_pressure_out,
    output logic signed [bvht_pkg::TEMP_W-1:0]   o_temperature_out
);

    logic [bvht_pkg::CFG_P_W-1:0]       r_min_p;
    logic [bvht_pkg::CFG_P_W-1:0]       r_max_p;
    logic signed [bvht_pkg::TEMP_W-1:0] r_min_t;
    logic signed [bvht_pkg::TEMP_W-1:0] r_max_t;
    logic [bvht_pkg::AGE_W-1:0]         r_stale;
    logic [bvht_pkg::DT_W-1:0]          r_min_iv;
    logic [bvht_pkg::DT_W-1:0]          r_max_iv;

    logic                               r_have_sample;
    logic                               r_last_valid;
    logic [bvht_pkg::TIME_W-1:0]        r_last_time;
    logic signed [bvht_pkg::ALT_W-1:0]  r_last_alt;
    logic signed [bvht_pkg::ALT_W-1:0]  r_last_climb;
    logic signed [bvht_pkg::PRES_W-1:0] r_last_p;
    logic signed [bvht_pkg::TEMP_W-1:0] r_last_t;

    logic                               r_mode;
    logic signed [bvht_pkg::PRES_W-1:0] r_p;
    logic signed [bvht_pkg::ALT_W-1:0]  r_a;
    logic signed [bvht_pkg::TEMP_W-1:0] r_t;
    logic [bvht_pkg::TIME_W-1:0]        r_now;

    logic                               r_valid;
    logic                               r_upd;
    logic [bvht_pkg::DT_W-1:0]          r_dt;

    logic signed [bvht_pkg::PA_W-1:0]   r_prod_a;
    logic signed [bvht_pkg::PB_W-1:0]   r_prod_b;
    logic [bvht_pkg::DEN_W-1:0]         r_den;
    logic signed [bvht_pkg::NUM_W-1:0]  r_num;
    logic                               r_neg;
    logic [bvht_pkg::MAG_W-1:0]         r_mag;
    logic                               r_sat;
    logic [bvht_pkg::REM_W-1:0]         r_rem;
    logic [bvht_pkg::QUO_W-1:0]         r_quo;
    logic [bvht_pkg::CNT_W-1:0]         r_cnt;

    logic                               r_out_valid;
    logic [1:0]                         r_out_health;
    logic                               r_out_sv;
    logic signed [bvht_pkg::ALT_W-1:0]  r_out_alt;
    logic signed [bvht_pkg::ALT_W-1:0]  r_out_climb;
    logic [bvht_pkg::AGE_W-1:0]         r_out_age;
    logic signed [bvht_pkg::PRES_W-1:0] r_out_p;
    logic signed [bvht_pkg::TEMP_W-1:0] r_out_t;

    logic [bvht_pkg::TIME_W-1:0]        w_dt48;
    logic                               w_valid;
    logic                               w_upd;
    logic signed [bvht_pkg::DA_W-1:0]   w_da;
    logic signed [bvht_pkg::NUM_W-1:0]  w_num;
    logic [bvht_pkg::NUM_W-1:0]         w_dsor_hi;
    logic [bvht_pkg::REM_W:0]           w_sh;
    logic [bvht_pkg::REM_W:0]           w_diff;
    logic                               w_ge;
    logic [bvht_pkg::ALT_W-1:0]         w_div_climb;
    logic [bvht_pkg::ALT_W-1:0]         w_climb_new;
    logic                               w_no_ref;
    logic [1:0]                         w_q_health;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_p  <= bvht_pkg::RST_MIN_P;
            r_max_p  <= bvht_pkg::RST_MAX_P;
            r_min_t  <= bvht_pkg::RST_MIN_T;
            r_max_t  <= bvht_pkg::RST_MAX_T;
            r_stale  <= bvht_pkg::RST_STALE;
            r_min_iv <= bvht_pkg::RST_MIN_IV;
            r_max_iv <= bvht_pkg::RST_MAX_IV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bvht_pkg::CFG_MIN_P:  r_min_p  <= i_cfg_data[bvht_pkg::CFG_P_W-1:0];
                bvht_pkg::CFG_MAX_P:  r_max_p  <= i_cfg_data[bvht_pkg::CFG_P_W-1:0];
                bvht_pkg::CFG_MIN_T:  r_min_t  <= i_cfg_data[bvht_pkg::TEMP_W-1:0];
                bvht_pkg::CFG_MAX_T:  r_max_t  <= i_cfg_data[bvht_pkg::TEMP_W-1:0];
                bvht_pkg::CFG_STALE:  r_stale  <= i_cfg_data;
                bvht_pkg::CFG_MIN_IV: r_min_iv <= i_cfg_data;
                bvht_pkg::CFG_MAX_IV: r_max_iv <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_dt48  = r_now - r_last_time;
    assign w_valid = ($signed({r_p[bvht_pkg::PRES_W-1], r_p})
                        >= $signed({15'd0, r_min_p}))
                  && ($signed({r_p[bvht_pkg::PRES_W-1], r_p})
                        <= $signed({15'd0, r_max_p}))
                  && (r_t >= r_min_t) && (r_t <= r_max_t);
    assign w_upd   = !r_mode && r_have_sample && r_last_valid && w_valid
                  && (r_last_time != '0) && (r_now > r_last_time)
                  && (w_dt48 >= {16'd0, r_min_iv}) && (w_dt48 <= {16'd0, r_max_iv});

    assign w_da  = {r_a[bvht_pkg::ALT_W-1], r_a}
                 - {r_last_alt[bvht_pkg::ALT_W-1], r_last_alt};
    assign w_num = bvht_pkg::NUM_W'(r_prod_a)
                 + (bvht_pkg::NUM_W'(r_prod_b) <<< 3)
                 - bvht_pkg::NUM_W'(r_prod_b);

    assign w_dsor_hi = {r_den, {bvht_pkg::QUO_W{1'b0}}};
    assign w_sh      = {r_rem, r_quo[bvht_pkg::QUO_W-1]};
    assign w_diff    = w_sh - {1'b0, r_den};
    assign w_ge      = (w_sh >= {1'b0, r_den});

    always_comb begin
        if (r_neg) begin
            if (r_sat || (r_quo > bvht_pkg::CLIMB_MIN)) begin
                w_div_climb = bvht_pkg::CLIMB_MIN;
            end else begin
                w_div_climb = -r_quo;
            end
        end else begin
            if (r_sat || r_quo[bvht_pkg::QUO_W-1]) begin
                w_div_climb = bvht_pkg::CLIMB_MAX;
            end else begin
                w_div_climb = r_quo;
            end
        end
    end

    assign w_climb_new = r_upd ? w_div_climb : '0;
    assign w_no_ref    = !r_have_sample || (r_last_time == '0);

    always_comb begin
        if (w_no_ref) begin
            w_q_health = bvht_pkg::HEALTH_INIT;
        end else if (!r_last_valid) begin
            w_q_health = bvht_pkg::HEALTH_INVALID;
        end else if (r_dt > r_stale) begin
            w_q_health = bvht_pkg::HEALTH_STALE;
        end else begin
            w_q_health = bvht_pkg::HEALTH_OK;
        end
    end

    // capture, check and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_p    <= i_pressure;
            r_a    <= i_altitude;
            r_t    <= i_temperature;
            r_now  <= i_time_us;
        end
        if (i_cmd.check) begin
            r_valid <= w_valid;
            r_upd   <= w_upd;
            r_dt    <= w_dt48[bvht_pkg::DT_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod_a <= bvht_pkg::PA_W'(w_da) * bvht_pkg::PA_W'(bvht_pkg::SPEED_K);
            r_prod_b <= bvht_pkg::PB_W'(r_last_climb)
                      * bvht_pkg::PB_W'($signed({1'b0, r_dt}));
            r_den    <= ({4'd0, r_dt} << 3) + ({4'd0, r_dt} << 1);
        end
        if (i_cmd.sum) begin
            r_num <= w_num;
        end
        if (i_cmd.mag) begin
            r_neg <= r_num[bvht_pkg::NUM_W-1];
            r_mag <= r_num[bvht_pkg::NUM_W-1] ? bvht_pkg::MAG_W'(-r_num)
                                              : bvht_pkg::MAG_W'(r_num);
        end
        if (i_cmd.div_init) begin
            r_sat <= ({1'b0, r_mag} >= w_dsor_hi);
            r_rem <= {1'b0, r_mag[bvht_pkg::MAG_W-1:bvht_pkg::QUO_W]};
            r_quo <= r_mag[bvht_pkg::QUO_W-1:0];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[bvht_pkg::REM_W-1:0] : w_sh[bvht_pkg::REM_W-1:0];
            r_quo <= {r_quo[bvht_pkg::QUO_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // stored sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_sample <= 1'b0;
            r_last_valid  <= 1'b0;
            r_last_time   <= '0;
            r_last_alt    <= '0;
            r_last_climb  <= '0;
            r_last_p      <= '0;
            r_last_t      <= '0;
        end else if (i_cmd.emit && !r_mode) begin
            r_have_sample <= 1'b1;
            r_last_valid  <= r_valid;
            r_last_time   <= r_now;
            r_last_alt    <= r_a;
            r_last_climb  <= w_climb_new;
            r_last_p      <= r_p;
            r_last_t      <= r_t;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_mode) begin
                r_out_health <= w_q_health;
                r_out_sv     <= r_last_valid;
                r_out_alt    <= r_last_alt;
                r_out_climb  <= r_last_climb;
                r_out_age    <= w_no_ref ? '0 : r_dt;
                r_out_p      <= r_last_p;
                r_out_t      <= r_last_t;
            end else begin
                r_out_health <= r_valid ? bvht_pkg::HEALTH_OK : bvht_pkg::HEALTH_INVALID;
                r_out_sv     <= r_valid;
                r_out_alt    <= r_a;
                r_out_climb  <= w_climb_new;
                r_out_age    <= '0;
                r_out_p      <= r_p;
                r_out_t      <= r_t;
            end
        end
    end

    assign o_sts.upd      = r_upd;
    assign o_sts.div_last = (r_cnt == bvht_pkg::DIV_LAST);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_health          = r_out_health;
    assign o_sample_valid    = r_out_sv;
    assign o_altitude_out    = r_out_alt;
    assign o_climb_rate      = r_out_climb;
    assign o_age             = r_out_age;
    assign o_pressure_out    = r_out_p;
    assign o_temperature_out = r_out_t;

    a_query_keeps_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_mode) |=> ($stable(r_last_time) && $stable(r_last_climb)))
        else $error("query changed the stored sample");

    a_no_update_zero_climb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_mode && !r_upd) |=> (r_last_climb == '0))
        else $error("climb kept without a speed update");

    a_sample_health: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_mode) |=> (r_out_valid
            && (r_out_health == bvht_pkg::HEALTH_OK
                || r_out_health == bvht_pkg::HEALTH_INVALID)
            && (r_out_age == '0)))
        else $error("sample word with query health or age");

endmodule

[hw/rtl/baro_vspeed_health_tracker.sv]
// channel    dir  modport             payload
// i_sample   in   bvht_in_if.sink     mode, pressure, altitude, temperature, time_us
// o_result   out  bvht_out_if.source  health, sample_valid, altitude_out, climb_rate,
//                                     age, pressure_out, temperature_out
// i_cfg_*    in   write port          we, index 0..6, data 32 bit
//
// One word in flight: a query or a sample without speed update passes capture, check
// and multiply and then emits its result; a sample with speed update also passes the
// sum, magnitude and divider-init steps and the bit-serial quotient loop of the
// datapath, which forms a 24-bit quotient, before it emits.
// Synchronous active-low reset clears the controller, the output valid, the
// stored sample and the configuration to its defaults.
// A stalled result holds in the output register; input ready returns while it waits,
// and the next word then holds in the controller until the result is taken.
module baro_vspeed_health_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bvht_in_if.sink                             i_sample,
    bvht_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [bvht_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bvht_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bvht_pkg::t_cmd w_cmd;
    bvht_pkg::t_sts w_sts;
    logic           w_in_ready;

    bvht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    assign i_sample.ready = w_in_ready;

    bvht_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_sample.mode),
        .i_pressure        (i_sample.pressure),
        .i_altitude        (i_sample.altitude),
        .i_temperature     (i_sample.temperature),
        .i_time_us         (i_sample.time_us),
        .o_out_valid       (o_result.valid),
        .i_out_ready       (o_result.ready),
        .o_health          (o_result.health),
        .o_sample_valid    (o_result.sample_valid),
        .o_altitude_out    (o_result.altitude_out),
        .o_climb_rate      (o_result.climb_rate),
        .o_age             (o_result.age),
        .o_pressure_out    (o_result.pressure_out),
        .o_temperature_out (o_result.temperature_out)
    );

endmodule

[tb/tb_baro_vspeed_health_tracker.sv]
`timescale 1ns / 100ps

module tb_baro_vspeed_health_tracker;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam longint RATE_HI = longint'($signed(bvht_pkg::CLIMB_MAX));
    localparam longint RATE_LO = longint'($signed(bvht_pkg::CLIMB_MIN));

    typedef struct packed {
        logic                               mode;
        logic signed [bvht_pkg::PRES_W-1:0] pressure;
        logic signed [bvht_pkg::ALT_W-1:0]  altitude;
        logic signed [bvht_pkg::TEMP_W-1:0] temperature;
        logic [bvht_pkg::TIME_W-1:0]        time_us;
    } t_baro_word;

    typedef struct packed {
        bvht_pkg::t_health                  health;
        logic                               sample_valid;
        logic signed [bvht_pkg::ALT_W-1:0]  altitude;
        logic signed [bvht_pkg::ALT_W-1:0]  climb;
        logic [bvht_pkg::AGE_W-1:0]         age;
        logic signed [bvht_pkg::PRES_W-1:0] pressure;
        logic signed [bvht_pkg::TEMP_W-1:0] temperature;
    } t_baro_status;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [bvht_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bvht_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bvht_in_if  sample_ch ();
    bvht_out_if result_ch ();

    baro_vspeed_health_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // limits and stored sample as the tracker should hold them
    logic [bvht_pkg::CFG_P_W-1:0]       lim_p_lo, lim_p_hi;
    logic signed [bvht_pkg::TEMP_W-1:0] lim_t_lo, lim_t_hi;
    logic [bvht_pkg::AGE_W-1:0]         stale_lim;
    logic [bvht_pkg::DT_W-1:0]          iv_lo, iv_hi;
    logic                               st_have, st_valid;
    logic [bvht_pkg::TIME_W-1:0]        st_time;
    logic signed [bvht_pkg::ALT_W-1:0]  st_alt, st_climb;
    logic signed [bvht_pkg::PRES_W-1:0] st_pres;
    logic signed [bvht_pkg::TEMP_W-1:0] st_temp;

    t_baro_status pending_status[$];
    int unsigned  err_count;

    logic [bvht_pkg::TIME_W-1:0]       trk_time;
    logic signed [bvht_pkg::ALT_W-1:0] trk_alt;
    bit                                src_idle, sink_idle, hold_req;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_baro_status track_baro_word(input t_baro_word w);
        t_baro_status                s;
        logic                        ok;
        logic [bvht_pkg::TIME_W-1:0] dt;
        longint                      num, den, rate;
        s.age = '0;
        if (w.mode == MODE_QUERY) begin
            if (!st_have || st_time == '0) begin
                s.health = bvht_pkg::HEALTH_INIT;
            end else begin
                s.age = bvht_pkg::AGE_W'(w.time_us - st_time);
                if (!st_valid) begin
                    s.health = bvht_pkg::HEALTH_INVALID;
                end else if (s.age > stale_lim) begin
                    s.health = bvht_pkg::HEALTH_STALE;
                end else begin
                    s.health = bvht_pkg::HEALTH_OK;
                end
            end
        end else begin
            ok = longint'(w.pressure) >= longint'(lim_p_lo)
                 && longint'(w.pressure) <= longint'(lim_p_hi)
                 && w.temperature >= lim_t_lo && w.temperature <= lim_t_hi;
            rate = 0;
            if (st_have && st_valid && ok && st_time != '0 && w.time_us > st_time) begin
                dt = w.time_us - st_time;
                if (dt >= bvht_pkg::TIME_W'(iv_lo)
                        && dt <= bvht_pkg::TIME_W'(iv_hi)) begin
                    num = 3 * (longint'(w.altitude) - longint'(st_alt)) * 64'sd10000000
                          + 7 * longint'(st_climb) * longint'(dt);
                    den = 10 * longint'(dt);
                    rate = num / den;
                    if (rate > RATE_HI) rate = RATE_HI;
                    if (rate < RATE_LO) rate = RATE_LO;
                end
            end
            st_have  = 1'b1;
            st_valid = ok;
            st_time  = w.time_us;
            st_alt   = w.altitude;
            st_climb = bvht_pkg::ALT_W'(rate);
            st_pres  = w.pressure;
            st_temp  = w.temperature;
            s.health = ok ? bvht_pkg::HEALTH_OK : bvht_pkg::HEALTH_INVALID;
        end
        s.sample_valid = st_valid;
        s.altitude     = st_alt;
        s.climb        = st_climb;
        s.pressure     = st_pres;
        s.temperature  = st_temp;
        return s;
    endfunction

    function automatic t_baro_word baro_word(input logic mode,
                                             input logic signed [bvht_pkg::PRES_W-1:0] p,
                                             input logic signed [bvht_pkg::ALT_W-1:0] a,
                                             input logic signed [bvht_pkg::TEMP_W-1:0] t,
                                             input logic [bvht_pkg::TIME_W-1:0] tm);
        t_baro_word w;
        w.mode        = mode;
        w.pressure    = p;
        w.altitude    = a;
        w.temperature = t;
        w.time_us     = tm;
        return w;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [bvht_pkg::PRES_W-1:0] draw_pressure(input bit on_edge);
        int lo, hi;
        lo = lim_p_lo;
        hi = lim_p_hi;
        if (!on_edge) return $urandom_range(lo, hi);
        case ($urandom_range(0, 3))
            0: return lo - 1;
            1: return lo;
            2: return hi;
            default: return hi + 1;
        endcase
    endfunction

    function automatic logic signed [bvht_pkg::TEMP_W-1:0] draw_temp(input bit on_edge);
        int lo, hi, tmp;
        lo = lim_t_lo;
        hi = lim_t_hi;
        if (on_edge) begin
            case ($urandom_range(0, 3))
                0: return bvht_pkg::TEMP_W'(lo - 1);
                1: return bvht_pkg::TEMP_W'(lo);
                2: return bvht_pkg::TEMP_W'(hi);
                default: return bvht_pkg::TEMP_W'(hi + 1);
            endcase
        end
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        return bvht_pkg::TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic [bvht_pkg::TIME_W-1:0] draw_spacing();
        longint lo, hi, tmp;
        lo = iv_lo;
        hi = iv_hi;
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        case ($urandom_range(0, 9))
            0: return bvht_pkg::TIME_W'(lo);
            1: return bvht_pkg::TIME_W'(hi);
            2: return bvht_pkg::TIME_W'($urandom);
            3: return bvht_pkg::TIME_W'(hi + 1);
            4: return bvht_pkg::TIME_W'((lo > 0) ? lo - 1 : 0);
            default: return bvht_pkg::TIME_W'(lo + $urandom_range(0,
                                 (hi - lo > 200000) ? 200000 : hi - lo));
        endcase
    endfunction

    function automatic logic [bvht_pkg::TIME_W-1:0] draw_age();
        longint s;
        s = stale_lim;
        case ($urandom_range(0, 9))
            0: return bvht_pkg::TIME_W'(s);
            1: return bvht_pkg::TIME_W'(s + 1);
            2: return bvht_pkg::TIME_W'($urandom);
            3: return bvht_pkg::TIME_W'(-longint'($urandom_range(1, 1000)));
            default: return bvht_pkg::TIME_W'($urandom_range(0, stale_lim));
        endcase
    endfunction

    function automatic logic signed [bvht_pkg::ALT_W-1:0] draw_alt_step();
        if ($urandom_range(0, 9) == 0) return bvht_pkg::ALT_W'($urandom);
        return bvht_pkg::ALT_W'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    task automatic send_word(input t_baro_word w);
        int gap;
        gap = src_idle ? draw_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sample_ch.valid       <= 1'b1;
        sample_ch.mode        <= w.mode;
        sample_ch.pressure    <= w.pressure;
        sample_ch.altitude    <= w.altitude;
        sample_ch.temperature <= w.temperature;
        sample_ch.time_us     <= w.time_us;
        do @(posedge i_clk); while (!sample_ch.ready);
        pending_status.push_back(track_baro_word(w));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [bvht_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bvht_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            bvht_pkg::CFG_MIN_P:  lim_p_lo  = data[bvht_pkg::CFG_P_W-1:0];
            bvht_pkg::CFG_MAX_P:  lim_p_hi  = data[bvht_pkg::CFG_P_W-1:0];
            bvht_pkg::CFG_MIN_T:  lim_t_lo  = data[bvht_pkg::TEMP_W-1:0];
            bvht_pkg::CFG_MAX_T:  lim_t_hi  = data[bvht_pkg::TEMP_W-1:0];
            bvht_pkg::CFG_STALE:  stale_lim = data;
            bvht_pkg::CFG_MIN_IV: iv_lo     = data;
            bvht_pkg::CFG_MAX_IV: iv_hi     = data;
            default: ;
        endcase
    endtask

    // upper bits above a narrow register carry junk the block must drop
    task automatic load_limits(input logic [bvht_pkg::CFG_P_W-1:0] plo, phi,
                               input logic signed [bvht_pkg::TEMP_W-1:0] tlo, thi,
                               input logic [bvht_pkg::AGE_W-1:0] stale,
                               input logic [bvht_pkg::DT_W-1:0] ivlo, ivhi);
        write_cfg(bvht_pkg::CFG_MIN_P, {14'($urandom), plo});
        write_cfg(bvht_pkg::CFG_MAX_P, {14'($urandom), phi});
        write_cfg(bvht_pkg::CFG_MIN_T, {16'($urandom), tlo});
        write_cfg(bvht_pkg::CFG_MAX_T, {16'($urandom), thi});
        write_cfg(bvht_pkg::CFG_STALE, stale);
        write_cfg(bvht_pkg::CFG_MIN_IV, ivlo);
        write_cfg(bvht_pkg::CFG_MAX_IV, ivhi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        t_baro_word w;
        int         roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3 || trk_time == '0) begin
                trk_time = $urandom_range(0, 1)
                           ? bvht_pkg::TIME_W'($urandom_range(1, 1000000))
                           : ({16'($urandom), 32'($urandom)} | 48'd1);
                trk_alt  = bvht_pkg::ALT_W'($urandom);
            end
            if (roll < 65) begin
                trk_time = trk_time + draw_spacing();
                trk_alt  = trk_alt + draw_alt_step();
                w = baro_word(MODE_SAMPLE, draw_pressure(1'b0), trk_alt, draw_temp(1'b0),
                              trk_time);
            end else if (roll < 85) begin
                w = baro_word(MODE_QUERY, bvht_pkg::PRES_W'($urandom),
                              bvht_pkg::ALT_W'($urandom), bvht_pkg::TEMP_W'($urandom),
                              trk_time + draw_age());
            end else if (roll < 92) begin
                w = baro_word(1'($urandom), bvht_pkg::PRES_W'($urandom),
                              bvht_pkg::ALT_W'($urandom), bvht_pkg::TEMP_W'($urandom),
                              {16'($urandom), 32'($urandom)});
            end else if (roll < 96) begin
                trk_time = trk_time + draw_spacing();
                trk_alt  = trk_alt + draw_alt_step();
                w = baro_word(MODE_SAMPLE, draw_pressure(1'b1), trk_alt, draw_temp(1'b1),
                              trk_time);
            end else begin
                trk_time = trk_time - bvht_pkg::TIME_W'($urandom_range(0, 100000));
                w = baro_word(MODE_SAMPLE, draw_pressure(1'b0), trk_alt, draw_temp(1'b0),
                              trk_time);
            end
            send_word(w);
        end
    endtask

    task automatic test_query_before_sample();
        send_word(baro_word(MODE_QUERY, 0, 0, 0, 48'd123456));
    endtask

    task automatic test_field_extremes();
        send_word(baro_word(MODE_SAMPLE, 32'sh7FFF_FFFF, 24'sh7F_FFFF, 16'sh7FFF,
                            48'hFFFF_FFFF_FFFF));
        send_word(baro_word(MODE_QUERY, 0, 0, 0, 48'd0));
        send_word(baro_word(MODE_SAMPLE, 32'sh8000_0000, 24'sh80_0000, 16'sh8000, 48'd0));
        send_word(baro_word(MODE_QUERY, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
        send_word(baro_word(MODE_SAMPLE, 101325, 0, 2000, 48'd0));
        send_word(baro_word(MODE_SAMPLE, 101325, 500, 2000, 48'd10000));
    endtask

    task automatic test_speed_update();
        send_word(baro_word(MODE_SAMPLE, 101325, 1000, 2000, 48'd2_000_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 1500, 2000, 48'd2_005_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 1400, 2000, 48'd3_005_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 1400, 2000, 48'd3_009_999));
        send_word(baro_word(MODE_SAMPLE, 101325, 1400, 2000, 48'd3_000_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 24'sh7F_FFFF, 2000, 48'd3_005_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 24'sh80_0000, 2000, 48'd3_010_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 0, 2000, 48'd3_010_000));
        send_word(baro_word(MODE_QUERY, 0, 0, 0, 48'd3_510_000));
        send_word(baro_word(MODE_QUERY, 0, 0, 0, 48'd3_510_001));
        send_word(baro_word(MODE_QUERY, 0, 0, 0, 48'd3_009_999));
    endtask

    task automatic test_inverted_bounds();
        drain_results();
        load_limits(18'd200000, 18'd100000, bvht_pkg::RST_MIN_T, bvht_pkg::RST_MAX_T,
                    bvht_pkg::RST_STALE, bvht_pkg::RST_MIN_IV, bvht_pkg::RST_MAX_IV);
        send_word(baro_word(MODE_SAMPLE, 150000, 100, 2000, 48'd3_500_000));
        drain_results();
        load_limits(bvht_pkg::RST_MIN_P, bvht_pkg::RST_MAX_P, 16'sd5000, -16'sd5000,
                    bvht_pkg::RST_STALE, bvht_pkg::RST_MIN_IV, bvht_pkg::RST_MAX_IV);
        send_word(baro_word(MODE_SAMPLE, 101325, 200, 0, 48'd3_600_000));
        drain_results();
        load_limits(bvht_pkg::RST_MIN_P, bvht_pkg::RST_MAX_P, bvht_pkg::RST_MIN_T,
                    bvht_pkg::RST_MAX_T, bvht_pkg::RST_STALE, 32'd2_000_000, 32'd1000);
        send_word(baro_word(MODE_SAMPLE, 101325, 300, 2000, 48'd4_000_000));
        send_word(baro_word(MODE_SAMPLE, 101325, 900, 2000, 48'd4_010_000));
    endtask

    task automatic test_config_sweep();
        logic [bvht_pkg::CFG_P_W-1:0] plo;
        logic [bvht_pkg::DT_W-1:0]    ivl;
        drain_results();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        load_limits(bvht_pkg::RST_MIN_P, bvht_pkg::RST_MAX_P, bvht_pkg::RST_MIN_T,
                    bvht_pkg::RST_MAX_T, bvht_pkg::RST_STALE, bvht_pkg::RST_MIN_IV,
                    bvht_pkg::RST_MAX_IV);
        run_random(340);

        drain_results();
        src_idle = 1'b0;
        load_limits(18'd0, 18'd262143, -16'sd32768, 16'sd32767, 32'd0,
                    32'd0, 32'hFFFF_FFFF);
        run_random(340);

        drain_results();
        src_idle  = 1'b1;
        sink_idle = 1'b0;
        load_limits(18'd95000, 18'd105000, 16'sd1000, 16'sd3000, 32'hFFFF_FFFF,
                    32'd1000, 32'd20000);
        run_random(340);

        drain_results();
        sink_idle = 1'b1;
        plo = bvht_pkg::CFG_P_W'($urandom_range(0, 100000));
        ivl = $urandom_range(0, 50000);
        load_limits(plo, plo + 18'($urandom_range(0, 150000)),
                    16'(-int'($urandom_range(0, 20000))), 16'($urandom_range(0, 20000)),
                    $urandom_range(1000, 2000000), ivl, ivl + $urandom_range(0, 500000));
        run_random(340);
    endtask

    // hold the result side off long enough for the input to back up
    task automatic test_backpressure();
        drain_results();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        hold_req  = 1'b1;
        run_random(25);
    endtask

    initial begin
        int stall, hold_left;
        stall           = 0;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (sink_idle && $urandom_range(0, 3) == 0) stall = draw_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_baro_status want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_status.size() == 0) begin
                $error("result word with nothing pending");
                err_count++;
            end else begin
                want = pending_status.pop_front();
                if (result_ch.health !== want.health) begin
                    $error("health: expected %0d, got %0d", want.health, result_ch.health);
                    err_count++;
                end
                if (result_ch.sample_valid !== want.sample_valid) begin
                    $error("sample_valid: expected %0d, got %0d", want.sample_valid,
                           result_ch.sample_valid);
                    err_count++;
                end
                if (result_ch.altitude_out !== want.altitude) begin
                    $error("altitude_out: expected %0d, got %0d", want.altitude,
                           result_ch.altitude_out);
                    err_count++;
                end
                if (result_ch.climb_rate !== want.climb) begin
                    $error("climb_rate: expected %0d, got %0d", want.climb,
                           result_ch.climb_rate);
                    err_count++;
                end
                if (result_ch.age !== want.age) begin
                    $error("age: expected %0d, got %0d", want.age, result_ch.age);
                    err_count++;
                end
                if (result_ch.pressure_out !== want.pressure) begin
                    $error("pressure_out: expected %0d, got %0d", want.pressure,
                           result_ch.pressure_out);
                    err_count++;
                end
                if (result_ch.temperature_out !== want.temperature) begin
                    $error("temperature_out: expected %0d, got %0d", want.temperature,
                           result_ch.temperature_out);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.mode        = MODE_SAMPLE;
        sample_ch.pressure    = '0;
        sample_ch.altitude    = '0;
        sample_ch.temperature = '0;
        sample_ch.time_us     = '0;
        err_count             = 0;
        src_idle              = 1'b0;
        sink_idle             = 1'b0;
        hold_req              = 1'b0;
        trk_time              = '0;
        trk_alt               = '0;
        lim_p_lo              = bvht_pkg::RST_MIN_P;
        lim_p_hi              = bvht_pkg::RST_MAX_P;
        lim_t_lo              = bvht_pkg::RST_MIN_T;
        lim_t_hi              = bvht_pkg::RST_MAX_T;
        stale_lim             = bvht_pkg::RST_STALE;
        iv_lo                 = bvht_pkg::RST_MIN_IV;
        iv_hi                 = bvht_pkg::RST_MAX_IV;
        st_have               = 1'b0;
        st_valid              = 1'b0;
        st_time               = '0;
        st_alt                = '0;
        st_climb              = '0;
        st_pres               = '0;
        st_temp               = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_query_before_sample();
        test_field_extremes();
        test_speed_update();
        test_inverted_bounds();
        test_config_sweep();
        test_backpressure();

        drain_results();
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
